// ===== rtl/core/aflm_pkg.sv =====
// Shared types and constants for the audio frame level meter.
// Used by the front, queue, back and top files; depends on nothing.
package aflm_pkg;

  localparam int MAX_FRAME = 512;
  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int SUM_W = 40;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic signed [15:0] DB_FLOOR = -16'sd23040;
  localparam logic [31:0] DB_K = 32'd101008905;
  localparam logic [23:0] RMS_MAX = 24'd8388608;
  localparam logic [4:0] SHIFT_RESET = 5'd14;
  localparam logic signed [15:0] THRESH_RESET = -16'sd9728;

  localparam logic REG_INPUT_SHIFT = 1'b0;
  localparam logic REG_VOICE_THRESH = 1'b1;

  typedef struct packed {
    logic signed [31:0] raw_word;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic frame_done;
    logic [23:0] rms_level;
    logic [15:0] peak_level;
    logic signed [15:0] dbfs_level;
    logic voice_flag;
    logic [31:0] frames_seen;
  } out_item_t;

  // one classified sample passed from front to back
  typedef struct packed {
    logic signed [15:0] pcm;
    logic done;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic [15:0] peak;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_SQRT, ST_LOGN, ST_LOGSQ, ST_DBMUL, ST_OUT
  } back_state_t;

endpackage

// ===== rtl/core/audio_frame_level_meter.sv =====
// Audio frame level meter top: config registers, front, job queue, back.
// Depends on aflm_pkg, aflm_front, aflm_queue, aflm_back.
//
// Usage: push raw 32-bit slot words with a last mark while full is low;
// one result per sample appears on result while empty is low and is taken
// with pop. Each result carries the saturated PCM sample and the stats held
// from the most recent completed frame (frame_done marks the closing one).
// Sequencing: an inner sample passes the back sequencer in take, output, pop;
// a frame-closing sample also runs the 56-step divider, the root (load, 28
// steps, finish) and, for a nonzero level, the 16-step log squaring loop.
// The back takes the next sample only after the last result is popped. The
// front accumulates at one sample per cycle while full is low into a 4-entry
// queue, so short bursts are absorbed. An accepted sample enters the queue,
// is taken by the back in ST_IDLE, and its result is registered in ST_OUT.
// Reset clears all frame state, shift to 14, threshold to -38 dB, and
// empties the queue. When the receiver stalls the result register holds,
// the back stops, the queue fills, and full rises.
module audio_frame_level_meter (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  aflm_pkg::in_item_t in_item,
  output logic empty,
  input  logic pop,
  output aflm_pkg::out_item_t result,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [15:0] cfg_data
);

  logic [4:0] input_shift;
  logic signed [15:0] voice_threshold_db;
  aflm_pkg::job_t fjob, qjob;
  logic qempty, take;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_shift <= aflm_pkg::SHIFT_RESET;
      voice_threshold_db <= aflm_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        aflm_pkg::REG_INPUT_SHIFT: input_shift <= cfg_data[4:0];
        aflm_pkg::REG_VOICE_THRESH: voice_threshold_db <= cfg_data;
        default: ;
      endcase
    end
  end

  aflm_front u_front (.clk, .rst, .input_shift, .in_valid(push && !full),
    .in_item, .job(fjob));

  aflm_queue u_queue (.clk, .rst, .wr(push), .wdata(fjob), .full,
    .rd(take), .rdata(qjob), .empty(qempty));

  aflm_back u_back (.clk, .rst, .voice_threshold_db, .job_avail(!qempty),
    .job(qjob), .job_take(take), .out_item(result), .empty, .pop);

endmodule

// ===== rtl/core/aflm_front.sv =====
// Front: shift/saturate, per-frame accumulation and frame-end detection.
// Depends on aflm_pkg.
module aflm_front (
  input  logic clk,
  input  logic rst,
  input  logic [4:0] input_shift,
  input  logic in_valid,
  input  aflm_pkg::in_item_t in_item,
  output aflm_pkg::job_t job
);

  logic [aflm_pkg::SUM_W-1:0] square_sum;
  logic [aflm_pkg::CNT_W-1:0] sample_count;
  logic [15:0] running_peak;

  logic signed [31:0] shifted;
  logic signed [15:0] s;
  logic [15:0] mag;
  logic [31:0] sq;
  logic [aflm_pkg::SUM_W:0] sum_wide;
  logic [aflm_pkg::SUM_W-1:0] sum_next;
  logic [aflm_pkg::CNT_W-1:0] count_next;
  logic [15:0] peak_next;
  logic done;

  always_comb begin
    shifted = in_item.raw_word >>> input_shift;
    if (shifted > 32'sd32767) s = 16'sd32767;
    else if (shifted < -32'sd32768) s = -16'sd32768;
    else s = shifted[15:0];
    mag = s[15] ? 16'(-s) : 16'(s);
    sq = mag * mag;
    sum_wide = {1'b0, square_sum} + {{(aflm_pkg::SUM_W - 31){1'b0}}, sq};
    sum_next = sum_wide[aflm_pkg::SUM_W] ? aflm_pkg::SUM_MAX : sum_wide[aflm_pkg::SUM_W-1:0];
    count_next = sample_count + 1'b1;
    peak_next = (mag > running_peak) ? mag : running_peak;
    done = in_item.last || (count_next >= aflm_pkg::CNT_W'(aflm_pkg::MAX_FRAME));
    job.pcm = s;
    job.done = done;
    job.sum = sum_next;
    job.count = count_next;
    job.peak = peak_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum <= '0;
      sample_count <= '0;
      running_peak <= '0;
    end else if (in_valid) begin
      if (done) begin
        square_sum <= '0;
        sample_count <= '0;
        running_peak <= '0;
      end else begin
        square_sum <= sum_next;
        sample_count <= count_next;
        running_peak <= peak_next;
      end
    end
  end

endmodule

// ===== rtl/core/aflm_queue.sv =====
// Small FIFO of classified jobs between front and back.
// Depends on aflm_pkg.
module aflm_queue (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  aflm_pkg::job_t wdata,
  output logic full,
  input  logic rd,
  output aflm_pkg::job_t rdata,
  output logic empty
);

  aflm_pkg::job_t mem [aflm_pkg::QDEPTH];
  logic [aflm_pkg::QPTR_W-1:0] wptr, rptr;
  logic [aflm_pkg::QPTR_W:0] fill;

  assign full = fill == (aflm_pkg::QPTR_W + 1)'(aflm_pkg::QDEPTH);
  assign empty = fill == '0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr && !full) wptr <= wptr + 1'b1;
      if (rd && !empty) rptr <= rptr + 1'b1;
      fill <= fill + (aflm_pkg::QPTR_W + 1)'(wr && !full) - (aflm_pkg::QPTR_W + 1)'(rd && !empty);
    end
  end

endmodule

// ===== rtl/core/aflm_back.sv =====
// Back: frame-end divide, square root, log2 and dB scaling; holds stats
// and the output register. Depends on aflm_pkg.
module aflm_back (
  input  logic clk,
  input  logic rst,
  input  logic signed [15:0] voice_threshold_db,
  input  logic job_avail,
  input  aflm_pkg::job_t job,
  output logic job_take,
  output aflm_pkg::out_item_t out_item,
  output logic empty,
  input  logic pop
);

  aflm_pkg::back_state_t state, state_next;

  logic [23:0] held_rms;
  logic [15:0] held_peak;
  logic signed [15:0] held_dbfs;
  logic held_voice;
  logic [31:0] frame_counter;

  logic signed [15:0] cur_pcm;
  logic cur_done;
  logic [15:0] cur_peak;

  // restoring divider: 56-bit dividend (sum << 16) by count
  logic [55:0] quo;
  logic [aflm_pkg::CNT_W:0] rem;
  logic [aflm_pkg::CNT_W-1:0] divisor;
  logic [5:0] step;
  // sqrt
  logic [55:0] sx;
  logic [55:0] sres;
  logic [57:0] sbit;
  // log
  logic [4:0] lexp;
  logic [31:0] lm;
  logic [15:0] lfrac;
  logic [23:0] rms_c;
  logic [20:0] dd;
  logic [48:0] prod;

  logic [aflm_pkg::CNT_W:0] rem_sh;
  logic [57:0] strial;
  logic [63:0] msq;
  logic [31:0] msq30;
  logic [4:0] e_c;
  logic [20:0] lg;
  logic [32:0] magr;
  logic signed [15:0] db_c;
  logic out_full;

  always_comb begin
    rem_sh = {rem[aflm_pkg::CNT_W-1:0], quo[55]};
    strial = {2'b0, sres} + sbit;
    msq = lm * lm;
    msq30 = msq[61:30];
    e_c = '0;
    for (int i = 1; i < 24; i++) if (rms_c[i]) e_c = 5'(i);
    lg = {lexp, lfrac};
    dd = 21'(23 << 16) - lg;
    magr = 33'((64'(dd) * aflm_pkg::DB_K + 64'h8000_0000) >> 32);
    if (rms_c == '0) db_c = aflm_pkg::DB_FLOOR;
    else if (lg >= 21'(23 << 16)) db_c = 16'sd0;
    else if (prod[48:0] > 49'd23040) db_c = aflm_pkg::DB_FLOOR;
    else db_c = -$signed(prod[15:0]);
  end

  always_comb begin
    state_next = state;
    case (state)
      aflm_pkg::ST_IDLE:
        if (job_avail && !out_full) state_next = job.done ? aflm_pkg::ST_DIV : aflm_pkg::ST_OUT;
      aflm_pkg::ST_DIV: if (step == 6'd55) state_next = aflm_pkg::ST_SQRT;
      aflm_pkg::ST_SQRT: if (sbit == '0) state_next = aflm_pkg::ST_LOGN;
      aflm_pkg::ST_LOGN: state_next = (rms_c == '0) ? aflm_pkg::ST_DBMUL : aflm_pkg::ST_LOGSQ;
      aflm_pkg::ST_LOGSQ: if (step == 6'd15) state_next = aflm_pkg::ST_DBMUL;
      aflm_pkg::ST_DBMUL: state_next = aflm_pkg::ST_OUT;
      aflm_pkg::ST_OUT: state_next = aflm_pkg::ST_IDLE;
      default: state_next = aflm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    job_take = (state == aflm_pkg::ST_IDLE) && job_avail && !out_full;
  end

  assign empty = !out_full;

  always_ff @(posedge clk) begin
    if (rst) state <= aflm_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      aflm_pkg::ST_IDLE: begin
        cur_pcm <= job.pcm;
        cur_done <= job.done;
        cur_peak <= job.peak;
        quo <= {job.sum, 16'b0};
        rem <= '0;
        divisor <= job.count;
        step <= '0;
      end
      aflm_pkg::ST_DIV: begin
        if (rem_sh >= {1'b0, divisor}) rem <= rem_sh - {1'b0, divisor};
        else rem <= rem_sh;
        quo <= {quo[54:0], rem_sh >= {1'b0, divisor}};
        step <= step + 1'b1;
        sres <= '0;
        sbit <= 58'(1) << 54;
      end
      aflm_pkg::ST_SQRT: begin
        if (step == 6'd56) begin
          sx <= quo;
          step <= '0;
        end else if (sbit != '0) begin
          if ({2'b0, sx} >= strial) begin
            sx <= 56'({2'b0, sx} - strial);
            sres <= 56'((sres >> 1) + sbit);
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
        end
        if (sbit == '0 || (sbit >> 2) == '0) rms_c <= (sres > 56'(aflm_pkg::RMS_MAX))
          ? aflm_pkg::RMS_MAX : sres[23:0];
      end
      aflm_pkg::ST_LOGN: begin
        lexp <= e_c;
        lm <= 32'({8'b0, rms_c} << (5'd30 - e_c));
        lfrac <= '0;
        step <= '0;
      end
      aflm_pkg::ST_LOGSQ: begin
        if (msq30[31:31] != 1'b0 || msq30 >= 32'h8000_0000) begin
          lm <= msq30 >> 1;
          lfrac <= {lfrac[14:0], 1'b1};
        end else begin
          lm <= msq30;
          lfrac <= {lfrac[14:0], 1'b0};
        end
        step <= step + 1'b1;
      end
      aflm_pkg::ST_DBMUL: begin
        prod <= 49'(magr);
      end
      default: ;
    endcase
  end

  // out register and held stats
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      held_rms <= '0;
      held_peak <= '0;
      held_dbfs <= aflm_pkg::DB_FLOOR;
      held_voice <= 1'b0;
      frame_counter <= '0;
    end else begin
      if (pop && out_full) out_full <= 1'b0;
      if (state == aflm_pkg::ST_OUT) begin
        out_full <= 1'b1;
        out_item.pcm_sample <= cur_pcm;
        out_item.frame_done <= cur_done;
        if (cur_done) begin
          held_rms <= rms_c;
          held_peak <= cur_peak;
          held_dbfs <= db_c;
          held_voice <= db_c > voice_threshold_db;
          frame_counter <= frame_counter + 1'b1;
          out_item.rms_level <= rms_c;
          out_item.peak_level <= cur_peak;
          out_item.dbfs_level <= db_c;
          out_item.voice_flag <= db_c > voice_threshold_db;
          out_item.frames_seen <= frame_counter + 1'b1;
        end else begin
          out_item.rms_level <= held_rms;
          out_item.peak_level <= held_peak;
          out_item.dbfs_level <= held_dbfs;
          out_item.voice_flag <= held_voice;
          out_item.frames_seen <= frame_counter;
        end
      end
    end
  end

`ifndef SYNTH
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    job_take |-> state == aflm_pkg::ST_IDLE) else $error("take outside idle");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == aflm_pkg::ST_OUT |-> !out_full || pop) else $error("result overwritten");
  a_count: assert property (@(posedge clk) disable iff (rst)
    (state == aflm_pkg::ST_OUT && cur_done) |=> frame_counter == $past(frame_counter) + 1)
    else $error("frame count slip");
`endif

endmodule
